// File: rtl/core/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants and types for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 64;

    localparam int KEY_W        = 64;
    localparam int DATA_W       = 32;
    localparam int CAP_W        = 5;
    localparam int CAP_RESET    = 16;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_PUT    = 1'b1;

    typedef struct packed {
        logic hit;
        logic evicted;
    } t_status;

endpackage

// File: rtl/core/lkvc_pick.sv
// ----------------------------------------------------------------------------
// lkvc_pick
// First-one picker: one-hot grant for the lowest set request bit.
// ----------------------------------------------------------------------------
module lkvc_pick #(
    parameter int N = lkvc_pkg::ENTRIES_DEF
) (
    input  logic [N-1:0] i_req,
    output logic [N-1:0] o_grant
);

    assign o_grant = i_req & (~i_req + N'(1));

endmodule

// File: rtl/core/lkvc_store.sv
// ----------------------------------------------------------------------------
// lkvc_store
// Entry store: parallel key match, free and oldest entry search, recency
// update and entry writes for one operation per cycle.
// ----------------------------------------------------------------------------
module lkvc_store #(
    parameter int ENTRIES  = lkvc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = lkvc_pkg::KEY_BITS_DEF,
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int FW      = $clog2(ENTRIES + 1),
    localparam int DW      = lkvc_pkg::DATA_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic                  i_kind,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [DW-1:0]         i_value,
    input  logic [FW-1:0]         i_cap,
    output lkvc_pkg::t_status     o_status,
    output logic [DW-1:0]         o_read_value,
    output logic [KEY_BITS-1:0]   o_evicted_key
);

    logic [ENTRIES-1:0]  r_valid;
    logic [AW-1:0]       r_age  [ENTRIES];
    logic [KEY_BITS-1:0] r_key  [ENTRIES];
    logic [DW-1:0]       r_data [ENTRIES];
    logic [FW-1:0]       r_fill;

    logic [ENTRIES-1:0]  match;
    logic [ENTRIES-1:0]  oldest;
    logic [ENTRIES-1:0]  hit_oh;
    logic [ENTRIES-1:0]  free_oh;
    logic [ENTRIES-1:0]  old_oh;
    logic [ENTRIES-1:0]  tgt;
    logic [AW-1:0]       old_age;
    logic [AW-1:0]       hit_age;
    logic [DW-1:0]       rd_data;
    logic [KEY_BITS-1:0] ev_key;
    logic                hit;
    logic                is_put;
    logic                room;
    logic                upd;
    logic                new_ent;
    logic                evict;
    logic [FW-1:0]       fill_m1;

    assign fill_m1 = r_fill - FW'(1);
    assign old_age = fill_m1[AW-1:0];

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = r_valid[i] && (r_key[i] == i_key);
            oldest[i] = r_valid[i] && (r_age[i] == old_age);
        end
    end

    lkvc_pick #(.N(ENTRIES)) u_pick_hit  (.i_req(match),    .o_grant(hit_oh));
    lkvc_pick #(.N(ENTRIES)) u_pick_free (.i_req(~r_valid), .o_grant(free_oh));
    lkvc_pick #(.N(ENTRIES)) u_pick_old  (.i_req(oldest),   .o_grant(old_oh));

    always_comb begin
        hit_age = '0;
        rd_data = '0;
        ev_key  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit_oh[i]) begin
                hit_age = hit_age | r_age[i];
                rd_data = rd_data | r_data[i];
            end
            if (old_oh[i]) begin
                ev_key = ev_key | r_key[i];
            end
        end
    end

    assign hit     = |match;
    assign is_put  = (i_kind == lkvc_pkg::KIND_PUT);
    assign room    = (r_fill < i_cap);
    assign upd     = i_fire && (hit || is_put);
    assign new_ent = is_put && !hit && room;
    assign evict   = is_put && !hit && !room;
    assign tgt     = hit ? hit_oh : (room ? free_oh : old_oh);

    assign o_status.hit     = hit;
    assign o_status.evicted = evict;
    assign o_read_value     = (hit && !is_put) ? rd_data : '0;
    assign o_evicted_key    = evict ? ev_key : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else if (upd) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (tgt[i]) begin
                    r_age[i] <= '0;
                end else if (r_valid[i] && (!hit || r_age[i] < hit_age)) begin
                    r_age[i] <= r_age[i] + AW'(1);
                end
            end
            if (new_ent) begin
                r_valid <= r_valid | tgt;
                r_fill  <= r_fill + FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (tgt[i]) begin
                    if (is_put) begin
                        r_data[i] <= i_value;
                    end
                    if (!hit) begin
                        r_key[i] <= i_key;
                    end
                end
            end
        end
    end

endmodule

// File: rtl/core/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
//
//   channel | valid      | ready        | payload
//   --------+------------+--------------+---------------------------------------
//   in      | i_in_valid | o_in_ready   | i_kind, i_key, i_value
//   out     | o_out_valid| i_out_ready  | o_hit, o_read_value, o_evicted,
//           |            |              | o_evicted_key
//   cfg     | i_cfg_valid| o_cfg_ready  | i_cfg_data (capacity)
//
// One item per cycle while results are taken. From input beat to result beat:
// input register, then one pass of key match and recency update into the result
// register. Entry state updates as the item moves into the result register.
// Synchronous reset empties the cache and sets capacity to 16 (clamped to
// ENTRIES). A stalled result holds the item behind it in the input register.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES  = lkvc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = lkvc_pkg::KEY_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_kind,
    input  logic [lkvc_pkg::KEY_W-1:0]         i_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] o_read_value,
    output logic                               o_evicted,
    output logic [lkvc_pkg::KEY_W-1:0]         o_evicted_key,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0]         i_cfg_data
);

    localparam int KW      = lkvc_pkg::KEY_W;
    localparam int DW      = lkvc_pkg::DATA_W;
    localparam int FW      = $clog2(ENTRIES + 1);
    localparam int CMPW    = (lkvc_pkg::CAP_W > FW) ? lkvc_pkg::CAP_W : FW;
    localparam int CAP_RST = (lkvc_pkg::CAP_RESET > ENTRIES) ? ENTRIES
                                                             : lkvc_pkg::CAP_RESET;

    logic                r_in_valid;
    logic                r_kind;
    logic [KEY_BITS-1:0] r_key;
    logic [DW-1:0]       r_value;
    logic [FW-1:0]       r_cap;
    logic                r_out_valid;
    logic                r_hit;
    logic [DW-1:0]       r_read_value;
    logic                r_evicted;
    logic [KEY_BITS-1:0] r_evicted_key;

    logic [CMPW-1:0]     cap_ext;
    logic [FW-1:0]       n_cap;
    logic                advance;

    lkvc_pkg::t_status   st_status;
    logic [DW-1:0]       st_read_value;
    logic [KEY_BITS-1:0] st_evicted_key;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        cap_ext = CMPW'(i_cfg_data);
        if (cap_ext == '0) begin
            n_cap = FW'(1);
        end else if (cap_ext > CMPW'(ENTRIES)) begin
            n_cap = FW'(ENTRIES);
        end else begin
            n_cap = cap_ext[FW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= FW'(CAP_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= n_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind  <= i_kind;
            r_key   <= i_key[KEY_BITS-1:0];
            r_value <= i_value;
        end
    end

    lkvc_store #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (advance),
        .i_kind        (r_kind),
        .i_key         (r_key),
        .i_value       (r_value),
        .i_cap         (r_cap),
        .o_status      (st_status),
        .o_read_value  (st_read_value),
        .o_evicted_key (st_evicted_key)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_hit         <= st_status.hit;
            r_read_value  <= st_read_value;
            r_evicted     <= st_status.evicted;
            r_evicted_key <= st_evicted_key;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_read_value  = r_read_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = KW'(r_evicted_key);

`ifndef SYNTHESIS
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("result register not loaded after advance");

    a_evict_is_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && st_status.evicted) |-> (r_kind == lkvc_pkg::KIND_PUT && !st_status.hit))
        else $error("eviction on lookup or hit");

    a_evict_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_evicted) |-> (!o_hit && o_read_value == '0))
        else $error("evicting result carries hit or read data");
`endif

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU key/value cache. A driver and a monitor run
// as clocked processes; every accepted beat is run through an in-bench copy of
// the cache and recency state, and each result beat is compared with the
// oldest predicted result. Capacity is rewritten between phases, including
// zero, values above the entry count and values below the current fill.
// ----------------------------------------------------------------------------
module tb_top;
    import lkvc_pkg::*;

    localparam int SLOTS = ENTRIES_DEF;

    typedef struct packed {
        logic                     kind;
        logic [KEY_W-1:0]         key;
        logic signed [DATA_W-1:0] value;
    } cache_op_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic [KEY_W-1:0]         evicted_key;
    } cache_result_t;

    logic                     i_clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_kind = KIND_LOOKUP;
    logic [KEY_W-1:0]         in_key = '0;
    logic signed [DATA_W-1:0] in_value = '0;
    logic                     out_ready = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [CAP_W-1:0]         cfg_data = '0;

    logic                     o_in_ready;
    logic                     o_out_valid;
    logic                     o_hit;
    logic signed [DATA_W-1:0] o_read_value;
    logic                     o_evicted;
    logic [KEY_W-1:0]         o_evicted_key;
    logic                     o_cfg_ready;

    cache_op_t     pending_ops[$];
    cache_result_t expected_results[$];
    cache_op_t     next_op;
    cache_result_t want;

    int ops_queued = 0;
    int ops_accepted = 0;
    int mismatches = 0;
    int send_idle = 20;
    int recv_idle = 78;
    int hold_left = 0;
    logic hold_armed = 1'b1;

    // predicted cache contents
    logic [CAP_W-1:0]         cap_reg = CAP_W'(CAP_RESET);
    logic                     slot_valid[SLOTS];
    logic [KEY_W-1:0]         slot_key[SLOTS];
    logic signed [DATA_W-1:0] slot_data[SLOTS];
    int                       slot_age[SLOTS];
    int                       fill_count = 0;

    lru_key_value_cache uut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (in_kind),
        .i_key        (in_key),
        .i_value      (in_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_hit        (o_hit),
        .o_read_value (o_read_value),
        .o_evicted    (o_evicted),
        .o_evicted_key(o_evicted_key),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1200000;
        $display("tb: failure");
        $finish;
    end

    function automatic int effective_capacity(logic [CAP_W-1:0] c);
        if (c == 0) return 1;
        if (c > SLOTS) return SLOTS;
        return int'(c);
    endfunction

    function automatic void make_recent(int s, int limit);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && i != s && slot_age[i] < limit) slot_age[i]++;
        end
        slot_age[s] = 0;
    endfunction

    function automatic cache_result_t cache_access(cache_op_t op);
        cache_result_t r;
        int slot;
        int cap;
        logic found;
        r = '0;
        slot = -1;
        found = 1'b0;
        cap = effective_capacity(cap_reg);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot < 0 && slot_valid[i] && slot_key[i] == op.key) slot = i;
        end
        if (slot >= 0) begin
            r.hit = 1'b1;
            if (op.kind == KIND_PUT) slot_data[slot] = op.value;
            else r.read_value = slot_data[slot];
            make_recent(slot, slot_age[slot]);
        end else if (op.kind == KIND_PUT) begin
            if (fill_count < cap) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot < 0 && !slot_valid[i]) slot = i;
                end
            end
            if (slot >= 0) begin
                make_recent(slot, 32'h7fff_ffff);
                slot_valid[slot] = 1'b1;
                fill_count++;
            end else begin
                slot = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_valid[i] && (!found || slot_age[i] > slot_age[slot])) begin
                        slot = i;
                        found = 1'b1;
                    end
                end
                r.evicted = 1'b1;
                r.evicted_key = slot_key[slot];
                make_recent(slot, slot_age[slot]);
            end
            slot_key[slot] = op.key;
            slot_data[slot] = op.value;
        end
        return r;
    endfunction

    task automatic note_mismatch(string field, logic [KEY_W-1:0] exp_v,
                                 logic [KEY_W-1:0] got_v);
        if (mismatches < 10)
            $display("mismatch on %s: expected %h, got %h", field, exp_v, got_v);
        mismatches++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_results.push_back(cache_access('{in_kind, in_key, in_value}));
                ops_accepted++;
            end
            if (!in_valid || o_in_ready) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle) begin
                    next_op = pending_ops.pop_front();
                    in_kind <= next_op.kind;
                    in_key <= next_op.key;
                    in_value <= next_op.value;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, once
    always @(posedge i_clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_armed && ops_accepted >= 200) begin
            hold_armed <= 1'b0;
            hold_left <= 120;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected beat", '0, o_evicted_key);
                end else begin
                    want = expected_results.pop_front();
                    if (o_hit !== want.hit)
                        note_mismatch("hit", KEY_W'(want.hit), KEY_W'(o_hit));
                    if (o_read_value !== want.read_value)
                        note_mismatch("read_value", KEY_W'(want.read_value),
                                      KEY_W'(o_read_value));
                    if (o_evicted !== want.evicted)
                        note_mismatch("evicted", KEY_W'(want.evicted), KEY_W'(o_evicted));
                    if (o_evicted_key !== want.evicted_key)
                        note_mismatch("evicted_key", want.evicted_key, o_evicted_key);
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic push_op(logic kind, logic [KEY_W-1:0] key, logic [DATA_W-1:0] value);
        pending_ops.push_back('{kind, key, value});
        ops_queued++;
    endtask

    task automatic settle();
        while (ops_accepted != ops_queued || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] c);
        cfg_valid <= 1'b1;
        cfg_data <= c;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        cfg_valid <= 1'b0;
        cap_reg = c;
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_phase(logic [CAP_W-1:0] c, int n);
        logic [KEY_W-1:0] pool[$];
        int pool_len;
        logic [KEY_W-1:0] k;
        pool_len = effective_capacity(c) + int'($urandom_range(0, 4));
        for (int i = 0; i < pool_len; i++) pool.push_back(random_key());
        write_capacity(c);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 85) k = pool[$urandom_range(pool_len - 1)];
            else k = random_key();
            push_op(1'($urandom_range(1)), k, $urandom());
        end
        settle();
    endtask

    localparam logic [KEY_W-1:0] KEY_A = 64'h5555_5555_5555_5555;
    localparam logic [KEY_W-1:0] KEY_B = 64'haaaa_aaaa_aaaa_aaaa;
    localparam logic [KEY_W-1:0] KEY_C = 64'h0123_4567_89ab_cdef;
    localparam logic [KEY_W-1:0] KEY_D = 64'hfedc_ba98_7654_3210;
    localparam logic [KEY_W-1:0] KEY_E = 64'h8000_0000_0000_0001;
    localparam logic [KEY_W-1:0] KEY_F = 64'h7fff_ffff_ffff_fffe;

    initial begin
        logic [CAP_W-1:0] caps[10];
        caps = '{5'd16, 5'd5, 5'd1, 5'd0, 5'd31, 5'd9, 5'd16, 5'd2, 5'd12, 5'd0};
        caps[9] = CAP_W'($urandom_range(31));
        for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i] = '0;
            slot_data[i] = '0;
            slot_age[i] = 0;
        end
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        push_op(KIND_LOOKUP, '0, 32'h1234_5678);
        push_op(KIND_PUT, '0, 32'h8000_0000);
        push_op(KIND_PUT, '1, 32'h7fff_ffff);
        push_op(KIND_LOOKUP, '1, '0);
        push_op(KIND_LOOKUP, '0, '1);
        push_op(KIND_PUT, '0, '1);
        push_op(KIND_LOOKUP, '0, '0);
        push_op(KIND_PUT, KEY_A, '0);
        push_op(KIND_PUT, KEY_B, 32'h0000_0001);
        push_op(KIND_LOOKUP, KEY_B, '0);
        settle();

        // shrink below the fill
        write_capacity(5'd2);
        push_op(KIND_PUT, KEY_C, 32'h0bad_f00d);
        push_op(KIND_LOOKUP, '1, '0);
        push_op(KIND_PUT, '1, 32'h5a5a_a5a5);
        settle();

        write_capacity(5'd0);
        push_op(KIND_PUT, KEY_D, 32'hdead_beef);
        push_op(KIND_LOOKUP, KEY_D, '0);
        push_op(KIND_PUT, '1, 32'h7fff_ffff);
        settle();

        write_capacity(5'd31);
        push_op(KIND_PUT, KEY_E, 32'h8000_0001);
        push_op(KIND_LOOKUP, KEY_E, '0);
        push_op(KIND_LOOKUP, KEY_A, '0);
        settle();

        write_capacity(5'd1);
        push_op(KIND_PUT, KEY_F, 32'hffff_fffe);
        push_op(KIND_LOOKUP, KEY_F, '0);
        settle();

        for (int p = 0; p < 10; p++) begin
            if (p == 4) begin
                send_idle = 78;
                recv_idle = 20;
            end else if (p == 7) begin
                send_idle = 0;
                recv_idle = 0;
            end
            random_phase(caps[p], 135);
        end

        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0)
            note_mismatch("missing beats", KEY_W'(expected_results.size()), '0);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
